>>> sv/mpfu_pkg.sv
package mpfu_pkg;

    localparam int NUM_CH  = 4;
    localparam int NUM_STG = 6;

    // Channel slots, in result order.
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;
    localparam int CH_A = 3;

    // Configuration register indexes.
    localparam logic [2:0] REG_BPP   = 3'd0;
    localparam logic [2:0] REG_RED   = 3'd1;
    localparam logic [2:0] REG_GREEN = 3'd2;
    localparam logic [2:0] REG_BLUE  = 3'd3;
    localparam logic [2:0] REG_ALPHA = 3'd4;

    // Pixel size codes that select a masked mode; every other code is RGB.
    localparam logic [2:0] BPP_M16   = 3'd2;
    localparam logic [2:0] BPP_M32   = 3'd4;
    localparam logic [2:0] RESET_BPP = BPP_M32;

    localparam logic [31:0] RESET_MASK [NUM_CH] = '{
        32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000
    };

    typedef enum logic [1:0] {
        MODE_RGB,
        MODE_M16,
        MODE_M32
    } t_mode;

    // Trailing zero count; an all-zero mask gives 32 so that the shift clears the word.
    function automatic logic [5:0] tz(input logic [31:0] m);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

    // Largest channel value in 16-bit mode: the mask moved down to bit 0, low 16 bits.
    function automatic logic [15:0] maxf_of(input logic [31:0] m);
        logic [31:0] s;
        s = m >> tz(m);
        return s[15:0];
    endfunction

    function automatic t_mode mode_of(input logic [2:0] bpp);
        t_mode md;
        if (bpp == BPP_M16) begin
            md = MODE_M16;
        end else if (bpp == BPP_M32) begin
            md = MODE_M32;
        end else begin
            md = MODE_RGB;
        end
        return md;
    endfunction

endpackage

>>> sv/masked_pixel_format_unpacker_top.sv
// Masked pixel unpacker. Each input item is one little-endian pixel word; each result
// item is 8-bit red, green, blue and alpha plus a has_alpha flag. In 4-byte mode a
// channel is the word ANDed with its mask, shifted down by the mask's trailing zero
// count and cut to 8 bits. In 2-byte mode the low 16 bits are masked the same way and
// the channel value v is scaled exactly to floor(v * 255 / maxfield), where maxfield is
// the shifted mask; a mask that leaves maxfield zero gives 0. Any other size code is
// 3-byte mode: bytes 0 and 2 swap places (BGR to RGB), alpha is 0 and has_alpha is low.
// The block takes one item per clock while o_in_ready is high. The depth is set
// by the 2-byte scaling: one stage extracts the fields, one forms v * 255, and four
// stages run a restoring divider, two quotient bits each.
// All modes share the same six-stage path so results always leave in order. A stall at
// the output holds the last stage; earlier stages keep filling bubbles, so the input
// stays ready until every stage is full. The configuration port is always ready;
// registers must be written only while no item is in flight.
module masked_pixel_format_unpacker_top
    import mpfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_pixel_word,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_has_alpha
);

    // Configuration. The shift count and maxfield of each mask are worked out when the
    // mask is written, so the item path never searches a mask.
    t_mode       r_mode;
    logic [31:0] r_mask [NUM_CH];
    logic [5:0]  r_sh   [NUM_CH];
    logic [15:0] r_maxf [NUM_CH];

    logic              bpp_we;
    logic [NUM_CH-1:0] mask_we;
    logic [5:0]        wr_sh;
    logic [15:0]       wr_maxf;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        bpp_we  = 1'b0;
        mask_we = '0;
        unique case (i_cfg_index)
            REG_BPP:   bpp_we        = 1'b1;
            REG_RED:   mask_we[CH_R] = 1'b1;
            REG_GREEN: mask_we[CH_G] = 1'b1;
            REG_BLUE:  mask_we[CH_B] = 1'b1;
            REG_ALPHA: mask_we[CH_A] = 1'b1;
            default:   ;
        endcase
        wr_sh   = tz(i_cfg_data);
        wr_maxf = maxf_of(i_cfg_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mode_of(RESET_BPP);
            for (int c = 0; c < NUM_CH; c++) begin
                r_mask[c] <= RESET_MASK[c];
                r_sh[c]   <= tz(RESET_MASK[c]);
                r_maxf[c] <= maxf_of(RESET_MASK[c]);
            end
        end else if (i_cfg_valid) begin
            if (bpp_we) begin
                r_mode <= mode_of(i_cfg_data[2:0]);
            end
            for (int c = 0; c < NUM_CH; c++) begin
                if (mask_we[c]) begin
                    r_mask[c] <= i_cfg_data;
                    r_sh[c]   <= wr_sh;
                    r_maxf[c] <= wr_maxf;
                end
            end
        end
    end

    // Pipeline. Stage 0 extracts, stage 1 forms v * 255, stages 2 to 5 divide.
    // r_stg_byte carries the finished value for the RGB and 4-byte modes.
    // r_stg_rem carries v, then v * 255, then the running remainder.
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] stg_rdy;
    t_mode              r_stg_mode [NUM_STG];
    t_mode              n_stg_mode [NUM_STG];
    logic [7:0]         r_stg_byte [NUM_STG][NUM_CH];
    logic [7:0]         n_stg_byte [NUM_STG][NUM_CH];
    logic [23:0]        r_stg_rem  [NUM_STG][NUM_CH];
    logic [23:0]        n_stg_rem  [NUM_STG][NUM_CH];
    logic [7:0]         r_stg_quo  [NUM_STG][NUM_CH];
    logic [7:0]         n_stg_quo  [NUM_STG][NUM_CH];

    logic [31:0] word_eff;
    logic [31:0] shv;
    logic [15:0] v;
    logic [23:0] t_rem;
    logic [23:0] d_sh;
    logic [7:0]  t_quo;
    logic [2:0]  bit_idx;

    // A stage can load when it is empty or when the stage after it moves on.
    always_comb begin
        stg_rdy[NUM_STG-1] = !r_vld[NUM_STG-1] || i_out_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    assign o_in_ready = stg_rdy[0];

    always_comb begin
        word_eff = '0;
        shv      = '0;
        v        = '0;
        t_rem    = '0;
        d_sh     = '0;
        t_quo    = '0;
        bit_idx  = '0;

        // Stage 0: mask and align each field. In 2-byte mode only the low half counts.
        n_vld[0]      = i_in_valid;
        n_stg_mode[0] = r_mode;
        word_eff      = (r_mode == MODE_M16) ? {16'h0000, i_pixel_word[15:0]} : i_pixel_word;
        for (int c = 0; c < NUM_CH; c++) begin
            shv = (word_eff & r_mask[c]) >> r_sh[c];
            if (r_mode == MODE_M32) begin
                n_stg_byte[0][c] = shv[7:0];
            end else if (r_mode == MODE_RGB && c != CH_A) begin
                // Red comes from byte 2 and blue from byte 0.
                n_stg_byte[0][c] = i_pixel_word[(2 - c) * 8 +: 8];
            end else begin
                n_stg_byte[0][c] = 8'h00;
            end
            n_stg_rem[0][c] = {8'h00, shv[15:0]};
            n_stg_quo[0][c] = 8'h00;
        end

        // Stage 1: v * 255 as (v << 8) - v.
        n_vld[1]      = r_vld[0];
        n_stg_mode[1] = r_stg_mode[0];
        for (int c = 0; c < NUM_CH; c++) begin
            v                = r_stg_rem[0][c][15:0];
            n_stg_byte[1][c] = r_stg_byte[0][c];
            n_stg_rem[1][c]  = {v, 8'h00} - {8'h00, v};
            n_stg_quo[1][c]  = 8'h00;
        end

        // Stages 2 to 5: restoring division by maxfield, most significant bits first.
        // The quotient never exceeds 255 because v is never above maxfield.
        for (int k = 2; k < NUM_STG; k++) begin
            n_vld[k]      = r_vld[k-1];
            n_stg_mode[k] = r_stg_mode[k-1];
            for (int c = 0; c < NUM_CH; c++) begin
                t_rem = r_stg_rem[k-1][c];
                t_quo = r_stg_quo[k-1][c];
                for (int j = 0; j < 2; j++) begin
                    bit_idx = 3'(11 - 2 * k - j);
                    d_sh    = {8'h00, r_maxf[c]} << bit_idx;
                    if (t_rem >= d_sh) begin
                        t_rem          = t_rem - d_sh;
                        t_quo[bit_idx] = 1'b1;
                    end
                end
                n_stg_byte[k][c] = r_stg_byte[k-1][c];
                n_stg_rem[k][c]  = t_rem;
                n_stg_quo[k][c]  = t_quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STG; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STG; k++) begin
            if (stg_rdy[k] && n_vld[k]) begin
                r_stg_mode[k] <= n_stg_mode[k];
                for (int c = 0; c < NUM_CH; c++) begin
                    r_stg_byte[k][c] <= n_stg_byte[k][c];
                    r_stg_rem[k][c]  <= n_stg_rem[k][c];
                    r_stg_quo[k][c]  <= n_stg_quo[k][c];
                end
            end
        end
    end

    // Result selection from the last stage, which doubles as the output register.
    logic [7:0] res [NUM_CH];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_stg_mode[NUM_STG-1] != MODE_M16) begin
                res[c] = r_stg_byte[NUM_STG-1][c];
            end else if (r_maxf[c] == 16'h0000) begin
                res[c] = 8'h00;
            end else begin
                res[c] = r_stg_quo[NUM_STG-1][c];
            end
        end
    end

    assign o_out_valid = r_vld[NUM_STG-1];
    assign o_red       = res[CH_R];
    assign o_green     = res[CH_G];
    assign o_blue      = res[CH_B];
    assign o_alpha     = res[CH_A];
    assign o_has_alpha = (r_stg_mode[NUM_STG-1] != MODE_RGB);

`ifndef ASSERT_OFF
    // A result without alpha must carry a zero alpha field.
    a_rgb_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_alpha |-> o_alpha == 8'h00)
        else $error("alpha not zero on an RGB result");

    // When the output drains, no stage may hold back the input.
    a_no_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output drains");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // After the last division step the remainder is below the divisor.
    for (genvar g = 0; g < NUM_CH; g++) begin : g_div_chk
        a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[NUM_STG-1] && r_stg_mode[NUM_STG-1] == MODE_M16 && r_maxf[g] != 16'h0000
            |-> r_stg_rem[NUM_STG-1][g] < {8'h00, r_maxf[g]})
            else $error("division remainder not below maxfield");
    end
`endif

endmodule

>>> verif/masked_pixel_format_unpacker_top_tb.sv
`timescale 1ns / 100ps

module masked_pixel_format_unpacker_top_tb;
    import mpfu_pkg::*;

    // Size codes beyond the two masked ones. All of them give the byte swap.
    localparam logic [2:0] BPP_RGB24    = 3'd3;
    localparam logic [2:0] BPP_SPARE_LO = 3'd0;
    localparam logic [2:0] BPP_SPARE_HI = 3'd7;

    // Register indexes past the last register. Writes to them must be dropped.
    localparam logic [2:0] REG_SPARE_A = 3'd5;
    localparam logic [2:0] REG_SPARE_B = 3'd6;
    localparam logic [2:0] REG_SPARE_C = 3'd7;

    localparam int SEGMENTS      = 24;
    localparam int SEG_ITEMS     = 23;
    localparam int PIPE_LATENCY  = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       has_alpha;
    } t_rgba;

    typedef enum logic {
        ROW_CFG,
        ROW_PIX
    } t_row_kind;

    // One row of the directed table. For a pixel row the index is unused and the data
    // is the pixel word. A typed row carries its result; others go through the predictor.
    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] data;
        bit          typed;
        t_rgba       res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [31:0] i_pixel_word = '0;
    logic        i_out_ready = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic        o_has_alpha;

    masked_pixel_format_unpacker_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel_word (i_pixel_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_alpha      (o_alpha),
        .o_has_alpha  (o_has_alpha)
    );

    // Free-running 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The testbench keeps its own copy of the registers, updated when a write is accepted.
    logic [2:0]  cfg_bpp = RESET_BPP;
    logic [31:0] cfg_mask [NUM_CH] = RESET_MASK;

    t_rgba       rgba_due [$];
    t_stim_row   plan [$];
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          fault_count = 0;
    int          pixels_sent = 0;
    int          results_seen = 0;
    int          reg_writes = 0;
    t_rgba       exp_res;
    t_rgba       got_res;

    // Position of the lowest set bit; an empty mask counts as 32.
    function automatic int unsigned low_zero_run(input logic [31:0] m);
        int unsigned n;
        n = 32;
        for (int b = 31; b >= 0; b--) begin
            if (m[b]) begin
                n = b;
            end
        end
        return n;
    endfunction

    // 4-byte channel: masked, moved down to bit 0, low byte kept.
    function automatic logic [7:0] take_field32(input logic [31:0] w, input logic [31:0] m);
        logic [31:0] f;
        if (m == '0) begin
            return 8'h00;
        end
        f = (w & m) >> low_zero_run(m);
        return f[7:0];
    endfunction

    // 2-byte channel: the field of the low half word scaled exactly to 0..255.
    function automatic logic [7:0] scale_field16(input logic [31:0] w, input logic [31:0] m);
        int unsigned sh;
        logic [31:0] top;
        logic [31:0] val;
        logic [31:0] q;
        if (m == '0) begin
            return 8'h00;
        end
        sh  = low_zero_run(m);
        top = (m >> sh) & 32'h0000_FFFF;
        if (top == '0) begin
            return 8'h00;
        end
        val = (({16'h0000, w[15:0]} & m) >> sh) & 32'h0000_FFFF;
        q   = (val * 32'd255) / top;
        if (q > 32'd255) begin
            q = 32'd255;
        end
        return q[7:0];
    endfunction

    // Result that the current register settings give for one pixel word.
    function automatic t_rgba unpack_pixel(input logic [31:0] w);
        t_rgba r;
        if (cfg_bpp == BPP_M32) begin
            r.red       = take_field32(w, cfg_mask[CH_R]);
            r.green     = take_field32(w, cfg_mask[CH_G]);
            r.blue      = take_field32(w, cfg_mask[CH_B]);
            r.alpha     = take_field32(w, cfg_mask[CH_A]);
            r.has_alpha = 1'b1;
        end else if (cfg_bpp == BPP_M16) begin
            r.red       = scale_field16(w, cfg_mask[CH_R]);
            r.green     = scale_field16(w, cfg_mask[CH_G]);
            r.blue      = scale_field16(w, cfg_mask[CH_B]);
            r.alpha     = scale_field16(w, cfg_mask[CH_A]);
            r.has_alpha = 1'b1;
        end else begin
            r.red       = w[23:16];
            r.green     = w[15:8];
            r.blue      = w[7:0];
            r.alpha     = 8'h00;
            r.has_alpha = 1'b0;
        end
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [2:0] idx, input logic [31:0] data);
        t_stim_row r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        r.typed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic t_stim_row pix_row(input logic [31:0] w);
        t_stim_row r;
        r.kind  = ROW_PIX;
        r.idx   = REG_BPP;
        r.data  = w;
        r.typed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic t_stim_row pix_exp(input logic [31:0] w, input logic [7:0] red,
                                          input logic [7:0] green, input logic [7:0] blue,
                                          input logic [7:0] alpha, input logic has_alpha);
        t_stim_row r;
        r.kind  = ROW_PIX;
        r.idx   = REG_BPP;
        r.data  = w;
        r.typed = 1'b1;
        r.res   = '{red: red, green: green, blue: blue, alpha: alpha, has_alpha: has_alpha};
        return r;
    endfunction

    // Mask shapes: empty, full, random bits, or a contiguous field. In 2-byte mode the
    // field always starts in the low half word so that the scaling is exercised.
    function automatic logic [31:0] rand_mask(input bit low_half);
        logic [63:0] field;
        int unsigned width;
        int unsigned pos;
        case ($urandom_range(9)) inside
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2, 3: begin
                return $urandom();
            end
            default: begin
                width = $urandom_range(1, 16);
                pos   = low_half ? $urandom_range(0, 15) : $urandom_range(0, 31);
                field = ((64'd1 << width) - 64'd1) << pos;
                return field[31:0];
            end
        endcase
    endfunction

    // Pixel words: extremes, words built from the masks so that fields reach their
    // maximum, and plain random words.
    function automatic logic [31:0] rand_pixel();
        logic [31:0] all_masks;
        all_masks = cfg_mask[CH_R] | cfg_mask[CH_G] | cfg_mask[CH_B] | cfg_mask[CH_A];
        case ($urandom_range(7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return all_masks;
            end
            3: begin
                return $urandom() & all_masks;
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%s", what);
        end
    endtask

    // Offer one pixel word, with random idle cycles in front of it. The expected result
    // is queued when the item is accepted.
    task automatic send_pixel(input logic [31:0] w, input bit typed, input t_rgba res);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_pixel_word <= w;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        rgba_due.push_back(typed ? res : unpack_pixel(w));
        pixels_sent++;
    endtask

    // Wait until every expected result has come back, then let the clock run on idle.
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (rgba_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    // Registers are only written with the pipeline empty.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        drain_pipe();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            REG_BPP:   cfg_bpp = data[2:0];
            REG_RED:   cfg_mask[CH_R] = data;
            REG_GREEN: cfg_mask[CH_G] = data;
            REG_BLUE:  cfg_mask[CH_B] = data;
            REG_ALPHA: cfg_mask[CH_A] = data;
            default: begin
            end
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker and receiver stall generator. Outputs are sampled at the edge,
    // before the block's own updates for that edge land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_res = '{red: o_red, green: o_green, blue: o_blue, alpha: o_alpha,
                        has_alpha: o_has_alpha};
            results_seen++;
            if (rgba_due.size() == 0) begin
                note_fault($sformatf("unexpected result r=%02h g=%02h b=%02h a=%02h ha=%0b",
                                     got_res.red, got_res.green, got_res.blue,
                                     got_res.alpha, got_res.has_alpha));
            end else begin
                exp_res = rgba_due.pop_front();
                if (got_res.red !== exp_res.red || got_res.green !== exp_res.green ||
                    got_res.blue !== exp_res.blue || got_res.alpha !== exp_res.alpha ||
                    got_res.has_alpha !== exp_res.has_alpha) begin
                    note_fault($sformatf({"result %0d mismatch: expected r=%02h g=%02h ",
                                          "b=%02h a=%02h ha=%0b, got r=%02h g=%02h b=%02h ",
                                          "a=%02h ha=%0b"},
                                         results_seen, exp_res.red, exp_res.green,
                                         exp_res.blue, exp_res.alpha, exp_res.has_alpha,
                                         got_res.red, got_res.green, got_res.blue,
                                         got_res.alpha, got_res.has_alpha));
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Main sequence: reset, the directed table, then random segments that each set up
    // the registers, pick an idling mix and stream a batch of pixel words.
    initial begin
        logic [2:0] seg_bpp;
        int         phase;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings first, then the byte swap under three codes, then 565 scaling
        // with an empty alpha mask, masks above the half word, full and single-bit masks,
        // and finally writes to indexes that do not exist.
        plan = '{
            pix_exp(32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1),
            pix_exp(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1),
            pix_exp(32'h1122_3344, 8'h22, 8'h33, 8'h44, 8'h11, 1'b1),
            cfg_row(REG_BPP, {29'd0, BPP_RGB24}),
            pix_exp(32'hAABB_CCDD, 8'hBB, 8'hCC, 8'hDD, 8'h00, 1'b0),
            pix_exp(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0),
            pix_exp(32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0),
            cfg_row(REG_BPP, {29'd0, BPP_SPARE_LO}),
            pix_exp(32'h0012_3456, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0),
            cfg_row(REG_BPP, {29'd0, BPP_SPARE_HI}),
            pix_exp(32'hFF00_FF00, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0),
            cfg_row(REG_BPP, {29'd0, BPP_M16}),
            cfg_row(REG_RED, 32'h0000_F800),
            cfg_row(REG_GREEN, 32'h0000_07E0),
            cfg_row(REG_BLUE, 32'h0000_001F),
            cfg_row(REG_ALPHA, 32'h0000_0000),
            pix_exp(32'h0000_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1),
            pix_exp(32'hFFFF_0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1),
            pix_row(32'h0000_8410),
            pix_row(32'h1234_5A5A),
            cfg_row(REG_ALPHA, 32'h0001_8000),
            pix_row(32'h0000_FFFF),
            pix_row(32'h0000_7FFF),
            cfg_row(REG_ALPHA, 32'h000F_0000),
            pix_row(32'hFFFF_FFFF),
            cfg_row(REG_RED, 32'hFFFF_FFFF),
            pix_exp(32'h0000_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1),
            pix_row(32'h0000_8000),
            cfg_row(REG_BPP, {29'd0, BPP_M32}),
            cfg_row(REG_RED, 32'h0000_0000),
            cfg_row(REG_GREEN, 32'hFFFF_FFFF),
            cfg_row(REG_BLUE, 32'h8000_0000),
            cfg_row(REG_ALPHA, 32'h0000_00F0),
            pix_row(32'hDEAD_BEEF),
            pix_exp(32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h01, 8'h0F, 1'b1),
            cfg_row(REG_SPARE_A, 32'h0000_0000),
            cfg_row(REG_SPARE_B, 32'hFFFF_FFFF),
            cfg_row(REG_SPARE_C, 32'h0000_0000),
            pix_row(32'hDEAD_BEEF)
        };

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                send_pixel(plan[k].data, plan[k].typed, plan[k].res);
            end
        end

        // Even segments run a masked mode with fresh masks; odd segments walk all eight
        // size codes. Each pair of segments shares one idling mix, so both kinds see all
        // four mixes.
        for (int s = 0; s < SEGMENTS; s++) begin
            if (s % 2 == 0) begin
                seg_bpp = (s % 4 == 0) ? BPP_M32 : BPP_M16;
            end else begin
                seg_bpp = 3'((s >> 1) % 8);
            end
            write_reg(REG_BPP, {29'd0, seg_bpp});
            if (s % 2 == 0) begin
                if (s == 2) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        write_reg(3'(REG_RED + c), 32'hFFFF_FFFF);
                    end
                end else if (s == 6) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        write_reg(3'(REG_RED + c), 32'h0000_0000);
                    end
                end else begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        write_reg(3'(REG_RED + c), rand_mask(seg_bpp == BPP_M16));
                    end
                end
            end

            phase = (s / 2) % 4;
            case (phase)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 48;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 48;
                end
                default: begin
                    src_idle_pct = 17;
                    sink_stall_pct = 17;
                end
            endcase

            for (int n = 0; n < SEG_ITEMS; n++) begin
                send_pixel(rand_pixel(), 1'b0, '0);
            end
        end

        src_idle_pct = 0;
        sink_stall_pct = 0;
        drain_pipe();
        repeat (4 * PIPE_LATENCY) @(posedge i_clk);

        if (rgba_due.size() != 0) begin
            note_fault($sformatf("%0d results never arrived", rgba_due.size()));
        end

        $display("Streamed %0d pixel words through all eight size codes with %0d %s",
                 pixels_sent, reg_writes, "register writes");
        $display("under four idling mixes; %0d results checked, %0d faults.",
                 results_seen, fault_count);
        if (fault_count == 0) begin
            $display("[masked_pixel_format_unpacker_top] OK");
        end else begin
            $display("[masked_pixel_format_unpacker_top] ERROR");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #400000;
        $display("Run timed out with %0d results still expected.", rgba_due.size());
        $display("[masked_pixel_format_unpacker_top] ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/mpfu_pkg.sv
sv/masked_pixel_format_unpacker_top.sv
verif/masked_pixel_format_unpacker_top_tb.sv
